[src/pbq_pkg.sv]
// Shared types, constants and pointer arithmetic for the packet buffer queue.
// No dependencies; imported by every module of the block.
package pbq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned ID_BITS = 8;
  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned IDP_W   = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned BYTE_W  = 20;
  localparam int unsigned ECNT_W  = 5;

  localparam logic [REQ_W-1:0] REQ_ENQ     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DEQ     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FLUSH   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REWIND  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ADVANCE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd5;

  typedef enum logic [2:0] {
    OP_ENQ,
    OP_DEQ,
    OP_FLUSH,
    OP_REWIND,
    OP_ADVANCE,
    OP_QUERY
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [ID_BITS-1:0] id;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] budget;
    logic              all;
  } cmd_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [LEN_W-1:0]   len;
  } entry_t;

  // Ring index plus an offset of at most DEPTH, wrapped into the ring.
  function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] idx,
                                                logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - PTR_W){1'b0}}, idx} + {1'b0, off};
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

[src/pbq_front.sv]
// Front end: accepts requests, decodes them into commands and queues them.
// Depends on pbq_pkg for the command type and request codes.
module pbq_front import pbq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [IDP_W-1:0]  buffer_id_i,
  input  logic [LEN_W-1:0]  buffer_length_i,
  input  logic [BYTE_W-1:0] flush_bytes_i,
  input  logic              flush_all_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_new;
  logic       push, pop;

  always_comb begin
    unique case (req_type_i)
      REQ_ENQ:     cmd_new.op = OP_ENQ;
      REQ_DEQ:     cmd_new.op = OP_DEQ;
      REQ_FLUSH:   cmd_new.op = OP_FLUSH;
      REQ_REWIND:  cmd_new.op = OP_REWIND;
      REQ_ADVANCE: cmd_new.op = OP_ADVANCE;
      REQ_QUERY:   cmd_new.op = OP_QUERY;
      default:     cmd_new.op = OP_QUERY;
    endcase
    cmd_new.id     = ID_BITS'(buffer_id_i);
    cmd_new.len    = buffer_length_i;
    cmd_new.budget = flush_bytes_i;
    cmd_new.all    = flush_all_i;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= cmd_new;
    end
  end

endmodule

[src/pbq_back.sv]
// Back end: entry store, queue pointers, flush walk and the result register.
// Depends on pbq_pkg for the command and entry types and pointer wrapping.
module pbq_back import pbq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [IDP_W-1:0]  out_id_o,
  output logic [LEN_W-1:0]  out_length_o,
  output logic              released_o,
  output logic              peek_valid_o,
  output logic [IDP_W-1:0]  peek_id_o,
  output logic [LEN_W-1:0]  peek_length_o,
  output logic [ECNT_W-1:0] entry_count_o,
  output logic [BYTE_W-1:0] bytes_held_o,
  output logic              is_empty_o,
  output logic              last_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EMIT  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_FEMIT = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d, emit_q, emit_d;
  logic [CNT_W-1:0]  count_q, count_d, peek_q, peek_d;
  logic [CNT_W-1:0]  walk_q, walk_d, rem_q, rem_d;
  logic [BYTE_W-1:0] bytes_q, bytes_d, budget_q, budget_d, sum_q, sum_d;
  logic              all_q, all_d;
  entry_t            rel_q, rel_d;
  logic              released_q, released_d;
  status_e           status_q, status_d;

  entry_t            mem [DEPTH];
  entry_t            rd_a_q, rd_p_q, wentry;
  logic              we;
  logic [PTR_W-1:0]  addr_a, addr_p;
  logic              take, out_free, out_load;

  logic              out_valid_q;
  status_e           o_status_q, o_status_d;
  entry_t            o_rel_q, o_rel_d;
  logic              o_released_q, o_released_d;
  logic              o_pv_q, o_pv_d;
  entry_t            o_peek_q, o_peek_d;
  logic [CNT_W-1:0]  o_count_q;
  logic [BYTE_W-1:0] o_bytes_q;
  logic              o_last_q, o_last_d;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;
  assign wentry      = '{id: cmd_i.id, len: cmd_i.len};
  assign take        = (walk_q < count_q) &&
                       (all_q || ((budget_q != '0) && (BYTE_W'(rd_a_q.len) <= budget_q)));

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    emit_d     = emit_q;
    count_d    = count_q;
    peek_d     = peek_q;
    walk_d     = walk_q;
    rem_d      = rem_q;
    bytes_d    = bytes_q;
    budget_d   = budget_q;
    sum_d      = sum_q;
    all_d      = all_q;
    rel_d      = rel_q;
    released_d = released_q;
    status_d   = status_q;
    we         = 1'b0;
    out_load   = 1'b0;
    o_status_d   = ST_OK;
    o_rel_d      = '0;
    o_released_d = 1'b0;
    o_last_d     = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d    = S_EMIT;
          released_d = 1'b0;
          status_d   = ST_OK;
          unique case (cmd_i.op)
            OP_ENQ: begin
              if (count_q == CNT_W'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                we      = 1'b1;
                tail_d  = wrap_add(tail_q, CNT_W'(1));
                count_d = count_q + CNT_W'(1);
                bytes_d = bytes_q + BYTE_W'(cmd_i.len);
              end
            end
            OP_DEQ: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                released_d = 1'b1;
                rel_d      = rd_a_q;
                head_d     = wrap_add(head_q, CNT_W'(1));
                count_d    = count_q - CNT_W'(1);
                bytes_d    = bytes_q - BYTE_W'(rd_a_q.len);
                peek_d     = (peek_q != '0) ? peek_q - CNT_W'(1) : '0;
              end
            end
            OP_FLUSH: begin
              state_d  = S_WALK;
              walk_d   = '0;
              budget_d = cmd_i.budget;
              sum_d    = '0;
              all_d    = cmd_i.all;
            end
            OP_REWIND: begin
              peek_d = '0;
            end
            OP_ADVANCE: begin
              if (peek_q < count_q) begin
                peek_d = peek_q + CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          o_status_d   = status_q;
          o_released_d = released_q;
          o_rel_d      = released_q ? rel_q : '0;
          state_d      = S_IDLE;
        end
      end
      S_WALK: begin
        if (take) begin
          walk_d   = walk_q + CNT_W'(1);
          budget_d = budget_q - BYTE_W'(rd_a_q.len);
          sum_d    = sum_q + BYTE_W'(rd_a_q.len);
        end else if (walk_q == '0) begin
          state_d = S_EMIT;
        end else begin
          head_d  = wrap_add(head_q, walk_q);
          count_d = count_q - walk_q;
          bytes_d = bytes_q - sum_q;
          peek_d  = (peek_q > walk_q) ? peek_q - walk_q : '0;
          emit_d  = head_q;
          rem_d   = walk_q;
          state_d = S_FEMIT;
        end
      end
      S_FEMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          o_released_d = 1'b1;
          o_rel_d      = rd_a_q;
          o_last_d     = (rem_q == CNT_W'(1));
          emit_d       = wrap_add(emit_q, CNT_W'(1));
          rem_d        = rem_q - CNT_W'(1);
          if (rem_q == CNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    o_pv_d   = (peek_q < count_q);
    o_peek_d = o_pv_d ? rd_p_q : '0;
  end

  // Read port A follows the head, the flush walk and the release sweep.
  always_comb begin
    addr_a = head_d;
    if (state_q == S_WALK) begin
      addr_a = take ? wrap_add(head_q, walk_q + CNT_W'(1)) : head_q;
    end else if (state_q == S_FEMIT) begin
      addr_a = (out_free && (rem_q == CNT_W'(1))) ? head_q : emit_d;
    end
    addr_p = wrap_add(head_d, peek_d);
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[tail_q] <= wentry;
    end
    rd_a_q <= (we && (tail_q == addr_a)) ? wentry : mem[addr_a];
    rd_p_q <= (we && (tail_q == addr_p)) ? wentry : mem[addr_p];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      peek_q      <= '0;
      bytes_q     <= '0;
      walk_q      <= '0;
      rem_q       <= '0;
      emit_q      <= '0;
      released_q  <= 1'b0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      peek_q     <= peek_d;
      bytes_q    <= bytes_d;
      walk_q     <= walk_d;
      rem_q      <= rem_d;
      emit_q     <= emit_d;
      released_q <= released_d;
      status_q   <= status_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    budget_q <= budget_d;
    sum_q    <= sum_d;
    all_q    <= all_d;
    rel_q    <= rel_d;
    if (out_load) begin
      o_status_q   <= o_status_d;
      o_rel_q      <= o_rel_d;
      o_released_q <= o_released_d;
      o_pv_q       <= o_pv_d;
      o_peek_q     <= o_peek_d;
      o_count_q    <= count_q;
      o_bytes_q    <= bytes_q;
      o_last_q     <= o_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = o_status_q;
  assign out_id_o      = IDP_W'(o_rel_q.id);
  assign out_length_o  = o_rel_q.len;
  assign released_o    = o_released_q;
  assign peek_valid_o  = o_pv_q;
  assign peek_id_o     = IDP_W'(o_peek_q.id);
  assign peek_length_o = o_peek_q.len;
  assign entry_count_o = ECNT_W'(o_count_q);
  assign bytes_held_o  = o_bytes_q;
  assign is_empty_o    = (o_count_q == '0);
  assign last_o        = o_last_q;

endmodule

[src/packet_buffer_queue_with_replay.sv]
// Packet buffer queue with replay position: top level joining front and back.
// Enqueue, dequeue, rewind, advance and query go through the back-end emit state;
// the result is registered, and no new command is taken until it is loaded.
// A flush gives a result per released entry, or one alone if it releases none.
// Reset clears pointers, counts, byte total, peek position and the valid handshakes;
// the entry store holds no defined contents until written. Depends on pbq_pkg.
module packet_buffer_queue_with_replay import pbq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [IDP_W-1:0]  buffer_id_i,
  input  logic [LEN_W-1:0]  buffer_length_i,
  input  logic [BYTE_W-1:0] flush_bytes_i,
  input  logic              flush_all_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [IDP_W-1:0]  out_id_o,
  output logic [LEN_W-1:0]  out_length_o,
  output logic              released_o,
  output logic              peek_valid_o,
  output logic [IDP_W-1:0]  peek_id_o,
  output logic [LEN_W-1:0]  peek_length_o,
  output logic [ECNT_W-1:0] entry_count_o,
  output logic [BYTE_W-1:0] bytes_held_o,
  output logic              is_empty_o,
  output logic              last_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  pbq_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .buffer_id_i     (buffer_id_i),
    .buffer_length_i (buffer_length_i),
    .flush_bytes_i   (flush_bytes_i),
    .flush_all_i     (flush_all_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd)
  );

  pbq_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .out_id_o      (out_id_o),
    .out_length_o  (out_length_o),
    .released_o    (released_o),
    .peek_valid_o  (peek_valid_o),
    .peek_id_o     (peek_id_o),
    .peek_length_o (peek_length_o),
    .entry_count_o (entry_count_o),
    .bytes_held_o  (bytes_held_o),
    .is_empty_o    (is_empty_o),
    .last_o        (last_o)
  );

`ifndef SYNTHESIS
  a_single_unreleased : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !released_o |-> last_o)
    else $error("result without a released buffer is not the last of its item");

  a_error_no_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> !released_o && last_o)
    else $error("error result hands back a buffer");

  a_peek_needs_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && peek_valid_o |-> (entry_count_o != '0) && !is_empty_o)
    else $error("peek entry reported on an empty queue");

  a_cmd_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && !cmd_ready |=> cmd_valid)
    else $error("queued command lost before transfer to back end");
`endif

endmodule
